FILE: rtl/bayer_bilinear_demosaic_core_defines.svh
`ifndef BAYER_BILINEAR_DEMOSAIC_CORE_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i with rst_ni low as disable.
`define BBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i with rst_ni low as disable.
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 12;
  localparam int REG_W  = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(1920);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(1080);
  localparam logic [REG_W-1:0] MIN_DIM      = REG_W'(3);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 2);

  typedef struct packed {
    logic [7:0] raw_sample;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [8:0][PIXEL_BITS-1:0] win;
    logic                       even_row;
    logic                       even_col;
    logic                       line_end;
    logic                       frame_end;
  } work_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/bbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_front import bbd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [REG_W-1:0]     cfg_data_i,
  input  wire logic                 accept_i,
  input  wire in_item_t             in_data_i,
  output logic                      busy_o,
  output logic                      push_o,
  output work_item_t                entry_o
);

  logic [REG_W-1:0] eff_w_q, eff_h_q;
  logic [COL_W-1:0] col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic             interior, line_end, frame_end, col_wrap, row_wrap;

  logic [2*PIXEL_BITS-1:0] line_mem_q [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q, fwd_data_q, pair;
  logic                    fwd_hit_q;

  logic                  f1_valid_q;
  logic [PIXEL_BITS-1:0] f1_sample_q;
  logic [COL_W-1:0]      f1_col_q;
  logic                  f1_interior_q, f1_even_row_q, f1_even_col_q;
  logic                  f1_line_end_q, f1_frame_end_q;

  logic [PIXEL_BITS-1:0] win_q [9];
  logic [PIXEL_BITS-1:0] win_d [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WIDTH_RESET;
      eff_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          if (cfg_data_i < MIN_DIM) begin
            eff_w_q <= MIN_DIM;
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            eff_w_q <= REG_W'(MAX_WIDTH);
          end else begin
            eff_w_q <= cfg_data_i;
          end
        end
        REG_FRAME_HEIGHT: begin
          eff_h_q <= (cfg_data_i < MIN_DIM) ? MIN_DIM : cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    col_cur   = in_data_i.frame_start ? '0 : col_q;
    row_cur   = in_data_i.frame_start ? '0 : row_q;
    interior  = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
                (REG_W'(row_cur) < eff_h_q) && (REG_W'(col_cur) < eff_w_q);
    line_end  = (REG_W'(col_cur) == (eff_w_q - REG_W'(1)));
    frame_end = line_end && (REG_W'(row_cur) == (eff_h_q - REG_W'(1)));
    col_wrap  = ({1'b0, REG_W'(col_cur)} + (REG_W + 1)'(1)) >= {1'b0, eff_w_q};
    row_wrap  = ({1'b0, REG_W'(row_cur)} + (REG_W + 1)'(1)) >= {1'b0, eff_h_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept_i;
      if (accept_i) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_cur + ROW_W'(1);
        end else begin
          col_q <= col_cur + COL_W'(1);
          row_q <= row_cur;
        end
      end
    end
  end

  // The line store word holds the upper line in the high half and the middle line below it.
  // A read that meets the write of the previous transfer at the same column takes the new word.
  assign pair = fwd_hit_q ? fwd_data_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q           <= line_mem_q[col_cur];
      fwd_hit_q      <= f1_valid_q && (f1_col_q == col_cur);
      fwd_data_q     <= {pair[PIXEL_BITS-1:0], f1_sample_q};
      f1_sample_q    <= in_data_i.raw_sample;
      f1_col_q       <= col_cur;
      f1_interior_q  <= interior;
      f1_even_row_q  <= row_cur[0];
      f1_even_col_q  <= col_cur[0];
      f1_line_end_q  <= line_end;
      f1_frame_end_q <= frame_end;
    end
    if (f1_valid_q) begin
      line_mem_q[f1_col_q] <= {pair[PIXEL_BITS-1:0], f1_sample_q};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = pair[2*PIXEL_BITS-1:PIXEL_BITS];
    win_d[5] = pair[PIXEL_BITS-1:0];
    win_d[8] = f1_sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (f1_valid_q) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      entry_o.win[i] = win_d[i];
    end
    entry_o.even_row  = f1_even_row_q;
    entry_o.even_col  = f1_even_col_q;
    entry_o.line_end  = f1_line_end_q;
    entry_o.frame_end = f1_frame_end_q;
  end

  assign push_o = f1_valid_q && f1_interior_q;
  assign busy_o = f1_valid_q;

endmodule

`default_nettype wire

FILE: rtl/bbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_queue import bbd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire work_item_t push_data_i,
  input  wire logic   pop_i,
  output work_item_t  head_o,
  output queue_status_t status_o
);

  work_item_t        entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

FILE: rtl/bbd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_back import bbd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire work_item_t    head_i,
  input  wire queue_status_t status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_data_o
);

  localparam int SUM_W = PIXEL_BITS + 2;

  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic [SUM_W-1:0]  orth_sum, diag_sum, vert_sum, horz_sum;
  logic [PIXEL_BITS-1:0] centre, orth, diag, vert, horz;
  logic [PIXEL_BITS-1:0] red, green, blue;

  assign pop_o = !status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    centre   = head_i.win[4];
    orth_sum = SUM_W'(head_i.win[1]) + SUM_W'(head_i.win[7]) +
               SUM_W'(head_i.win[3]) + SUM_W'(head_i.win[5]);
    diag_sum = SUM_W'(head_i.win[0]) + SUM_W'(head_i.win[2]) +
               SUM_W'(head_i.win[6]) + SUM_W'(head_i.win[8]);
    vert_sum = SUM_W'(head_i.win[1]) + SUM_W'(head_i.win[7]);
    horz_sum = SUM_W'(head_i.win[3]) + SUM_W'(head_i.win[5]);
    orth     = orth_sum[SUM_W-1:2];
    diag     = diag_sum[SUM_W-1:2];
    vert     = vert_sum[PIXEL_BITS:1];
    horz     = horz_sum[PIXEL_BITS:1];

    if (head_i.even_row && head_i.even_col) begin
      red = diag;   green = orth;   blue = centre;
    end else if (!head_i.even_row && !head_i.even_col) begin
      red = centre; green = orth;   blue = diag;
    end else if (head_i.even_row) begin
      red = vert;   green = centre; blue = horz;
    end else begin
      red = horz;   green = centre; blue = vert;
    end

    out_d.red       = red[7:0];
    out_d.green     = green[7:0];
    out_d.blue      = blue[7:0];
    out_d.line_end  = head_i.line_end;
    out_d.frame_end = head_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/bayer_bilinear_demosaic_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_i: raw_sample, frame_start
// out       output     out_valid_o/out_stall_i out_data_o: red, green, blue, line_end, frame_end
// cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// A sample is taken per cycle unless stalled; it passes front, queue and output registers.
// The rate is set by the single line store word that is read and rewritten once per sample.
// Reset clears the counters, window and queue; the line store needs no clearing pass.
// A stalled output fills a four-entry queue, and the input stalls once it cannot take more.
`timescale 1ns / 1ps
`default_nettype none
`include "bayer_bilinear_demosaic_core_defines.svh"

module bayer_bilinear_demosaic_core import bbd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [REG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  logic          accept, front_busy, push, pop;
  work_item_t    push_data, head;
  queue_status_t queue_status;

  assign in_stall_o = (queue_status.count + QCNT_W'(front_busy)) >= QCNT_W'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  bbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .busy_o      (front_busy),
    .push_o      (push),
    .entry_o     (push_data)
  );

  bbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (queue_status)
  );

  bbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (queue_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `BBD_ASSERT_NOW(a_queue_room, push, queue_status.count < QCNT_W'(QDEPTH), "queue overflow")
  `BBD_ASSERT_NOW(a_frame_end_line_end, out_valid_o && out_data_o.frame_end, out_data_o.line_end, "frame end without line end")
  `BBD_ASSERT_NEXT(a_queue_drains, !queue_status.empty && !out_stall_i, out_valid_o, "queued transfer not presented")

endmodule

`default_nettype wire

FILE: tb/demosaic_checker.sv
`timescale 1ns / 1ps

module demosaic_checker
  import bbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [PIXEL_BITS-1:0] upper_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] window [9];
  logic [REG_W-1:0]      width_reg;
  logic [REG_W-1:0]      height_reg;
  logic [REG_W-1:0]      col_cnt;
  logic [ROW_W-1:0]      row_cnt;
  out_item_t             expected_rgb_q [$];
  int                    mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic predict_pixel(input in_item_t item);
    logic [REG_W-1:0]      w;
    logic [REG_W-1:0]      h;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    logic [9:0]            orth;
    logic [9:0]            diag;
    logic [8:0]            vert;
    logic [8:0]            horz;
    logic [ROW_W-1:0]      cy;
    logic [REG_W-1:0]      cx;
    logic                  even_row;
    logic                  even_col;
    out_item_t             rgb;
    w = (width_reg < MIN_DIM) ? MIN_DIM :
        (width_reg > REG_W'(MAX_WIDTH)) ? REG_W'(MAX_WIDTH) : width_reg;
    h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    if (item.frame_start) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    up = upper_line[col_cnt[COL_W-1:0]];
    mid = middle_line[col_cnt[COL_W-1:0]];
    upper_line[col_cnt[COL_W-1:0]] = mid;
    middle_line[col_cnt[COL_W-1:0]] = item.raw_sample;
    for (int r = 0; r < 3; r++) begin
      window[3*r] = window[3*r+1];
      window[3*r+1] = window[3*r+2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = item.raw_sample;

    if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < h && col_cnt < w) begin
      cy = row_cnt - 1'b1;
      cx = col_cnt - 1'b1;
      even_row = ~cy[0];
      even_col = ~cx[0];
      orth = 10'(window[1]) + 10'(window[7]) + 10'(window[3]) + 10'(window[5]);
      diag = 10'(window[0]) + 10'(window[2]) + 10'(window[6]) + 10'(window[8]);
      vert = 9'(window[1]) + 9'(window[7]);
      horz = 9'(window[3]) + 9'(window[5]);
      if (even_row && even_col) begin
        rgb.red = diag[9:2];
        rgb.green = orth[9:2];
        rgb.blue = window[4];
      end else if (!even_row && !even_col) begin
        rgb.red = window[4];
        rgb.green = orth[9:2];
        rgb.blue = diag[9:2];
      end else if (even_row) begin
        rgb.red = vert[8:1];
        rgb.green = window[4];
        rgb.blue = horz[8:1];
      end else begin
        rgb.red = horz[8:1];
        rgb.green = window[4];
        rgb.blue = vert[8:1];
      end
      rgb.line_end = (col_cnt == w - 1'b1);
      rgb.frame_end = rgb.line_end && (row_cnt == h - 1'b1);
      expected_rgb_q.push_back(rgb);
    end

    if (int'(col_cnt) + 1 >= int'(w)) begin
      col_cnt = '0;
      row_cnt = (int'(row_cnt) + 1 >= int'(h)) ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_rgb_q.size() == 0) begin
      $error("unexpected output transfer: red %0d green %0d blue %0d",
             got.red, got.green, got.blue);
      mismatches++;
    end else begin
      want = expected_rgb_q.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.line_end !== want.line_end) begin
        $error("line_end: expected %0d, actual %0d", want.line_end, got.line_end);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) begin
        window[i] = '0;
      end
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_cnt = '0;
      row_cnt = '0;
      expected_rgb_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH: width_reg = cfg_data_i;
          REG_FRAME_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_pixel(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_pixel(out_data_i);
      end
      pending_o <= expected_rgb_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bbd_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  int                   fail_count;
  int                   pending;

  logic [REG_W-1:0]     width_set = WIDTH_RESET;
  logic [REG_W-1:0]     height_set = HEIGHT_RESET;
  int unsigned          pixel_col = 0;
  int unsigned          pixel_row = 0;
  int unsigned          random_items = 0;
  logic                 quiet = 1'b0;
  logic                 hold_request = 1'b0;
  logic                 hold_done = 1'b0;

  bayer_bilinear_demosaic_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  demosaic_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned active_width();
    if (width_set < MIN_DIM) return MIN_DIM;
    if (width_set > REG_W'(MAX_WIDTH)) return MAX_WIDTH;
    return width_set;
  endfunction

  function automatic int unsigned active_height();
    return (height_set < MIN_DIM) ? MIN_DIM : height_set;
  endfunction

  task automatic push_sample(input logic [7:0] sample, input logic start);
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{raw_sample: sample, frame_start: start};
    do @(posedge clk); while (in_stall);
    if (start) begin
      pixel_col = 0;
      pixel_row = 0;
    end
    if (pixel_col + 1 >= active_width()) begin
      pixel_col = 0;
      pixel_row = (pixel_row + 1 >= active_height()) ? 0 : pixel_row + 1;
    end else begin
      pixel_col++;
    end
  endtask

  // The block can still hold a sample that makes no result, so allow for its latency.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_set = w;
    height_set = h;
  endtask

  // The receiver runs on its own; one long hold-off lets the block back up into its input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 20);
      end
    end
  end

  initial begin
    int unsigned rows_left;
    int unsigned lines;
    int unsigned cut;
    int unsigned guard;
    logic        start;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_geometry(12'd0, 12'd1);
    for (int i = 0; i < 9; i++) begin
      push_sample(8'hFF, i == 0);
    end
    drain_pipeline();
    write_geometry(12'd4, 12'd4);
    for (int i = 0; i < 16; i++) begin
      push_sample(8'(i * 17), i == 0);
    end

    drain_pipeline();
    write_geometry(12'hFFF, 12'd2);
    for (int i = 0; i < 200; i++) begin
      push_sample(8'($urandom), i == 0);
    end
    drain_pipeline();
    write_geometry(12'd3, 12'hFFF);
    hold_request = 1'b1;
    for (int i = 0; i < 90; i++) begin
      push_sample(8'($urandom), i == 0);
    end
    drain_pipeline();
    write_geometry(12'd6, 12'd5);

    while (random_items < 800) begin
      quiet = (random_items >= 500 && random_items < 700);
      start = ($urandom_range(99) < 30);
      if ($urandom_range(99) < 35) begin
        drain_pipeline();
        if (pixel_row != 0 && $urandom_range(1) == 1) begin
          write_geometry(width_set, 12'($urandom_range(8)));
          start = 1'b0;
        end else begin
          write_geometry(($urandom_range(19) == 0) ? 12'($urandom_range(40, 13)) :
                         12'($urandom_range(12)), 12'($urandom_range(8)));
          if (pixel_row != 0) start = 1'b1;
        end
      end
      if (start) begin
        rows_left = active_height();
      end else begin
        rows_left = (pixel_row >= active_height()) ? 1 : active_height() - pixel_row;
      end
      lines = ($urandom_range(99) < 70) ? rows_left : $urandom_range(rows_left, 1);
      repeat (lines) begin
        push_sample(8'($urandom), start);
        start = 1'b0;
        random_items++;
        while (pixel_col != 0) begin
          push_sample(8'($urandom), 1'b0);
          random_items++;
        end
      end
      if ($urandom_range(99) < 10 && active_width() >= 5) begin
        cut = $urandom_range(active_width() - 1, 3);
        repeat (cut) begin
          push_sample(8'($urandom), 1'b0);
          random_items++;
        end
        drain_pipeline();
        write_geometry(12'($urandom_range(cut)), height_set);
        while (pixel_col != 0) begin
          push_sample(8'($urandom), 1'b0);
          random_items++;
        end
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bbd_front.sv
rtl/bbd_queue.sv
rtl/bbd_back.sv
rtl/bayer_bilinear_demosaic_core.sv
tb/demosaic_checker.sv
tb/tb.sv
